[src/cdq_pkg.sv]
`default_nettype none

package cdq_pkg;

	localparam int unsigned DEPTH_DEF      = 1024;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_POP_FRONT  = 2'd1,
		ACT_PUSH_BACK  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SEEK = 1'b1
	} state_t;

	typedef struct packed {
		logic rot_left;
		logic rot_right;
		logic load;
	} ring_cmd_t;

endpackage

`default_nettype wire

[src/cdq_cell.sv]
`default_nettype none

module cdq_cell #(
	parameter int unsigned DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  wire                    clk,
	input  cdq_pkg::ring_cmd_t     cmd,
	input  wire [DATA_WIDTH-1:0]   load_data,
	input  wire [DATA_WIDTH-1:0]   from_left,
	input  wire [DATA_WIDTH-1:0]   from_right,
	output logic [DATA_WIDTH-1:0]  data
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_q <= load_data;
		end else if (cmd.rot_left) begin
			data_q <= from_right;
		end else if (cmd.rot_right) begin
			data_q <= from_left;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

[src/cdq_ring.sv]
`default_nettype none

module cdq_ring #(
	parameter int unsigned DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  wire                    clk,
	input  cdq_pkg::ring_cmd_t     cmd,
	input  wire [DATA_WIDTH-1:0]   load_data,
	output logic [DATA_WIDTH-1:0]  port_data
);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cdq_pkg::ring_cmd_t cell_cmd;

		assign cell_cmd.rot_left  = cmd.rot_left;
		assign cell_cmd.rot_right = cmd.rot_right;
		assign cell_cmd.load      = (i == 0) ? cmd.load : 1'b0;

		cdq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cell_cmd),
			.load_data (load_data),
			.from_left (cell_data[(i + DEPTH - 1) % DEPTH]),
			.from_right(cell_data[(i + 1) % DEPTH]),
			.data      (cell_data[i])
		);
	end

	assign port_data = cell_data[0];

endmodule

`default_nettype wire

[src/circular_deque_checker_core.sv]
// Double-ended queue with a self-checking pop path.
// Command channel (cmd_valid/cmd_ready): action and value. Pushes store value at the
// front or back; pops take the front or back entry and compare it with value.
// Response channel (rsp_valid/rsp_ready): one response per command with the popped
// value (all ones on an empty pop, zero on a push), empty/overflow flags, the compare
// result, the sticky all_matched flag and the occupancy after the command.
// Storage is a ring of DEPTH cells that rotates one step per cycle in either direction;
// the single access port sits at cell 0. A command waits until its slot has rotated to
// the port, taking the shorter way round.
// A command is latched at accept, rotates the ring in the seek state until its slot is at
// the port, and then finishes. A full push or an empty pop needs no rotation.
// A command is taken only when the previous one has finished, so a new command is not
// accepted while one is in progress. A finished response waits in an output register
// while the next command is accepted; if the receiver still stalls when the next command
// finishes, that command holds at the port until the register frees.
// Reset empties the deque and sets the sticky match flag; cells and response data are not cleared.
`default_nettype none

module circular_deque_checker_core #(
	parameter int unsigned DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cmd_valid,
	output logic                                 cmd_ready,
	input  wire [1:0]                            action,
	input  wire signed [DATA_WIDTH-1:0]          value,
	output logic                                 rsp_valid,
	input  wire                                  rsp_ready,
	output logic signed [DATA_WIDTH-1:0]         popped_value,
	output logic                                 was_empty,
	output logic                                 overflowed,
	output logic                                 matched,
	output logic                                 all_matched,
	output logic [$clog2(DEPTH+1)-1:0]           occupancy
);

	localparam int unsigned PW   = $clog2(DEPTH);
	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned HALF = DEPTH / 2;

	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	cdq_pkg::state_t  state_q, state_d;
	cdq_pkg::action_t act_q;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [PW-1:0]    tgt_q, tgt_d;
	logic [PW-1:0]    front_q, back_q, rot_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             all_ok_q, all_ok_d;
	logic             rsp_valid_q;

	logic             is_push, full, empty, need_access, at_slot, out_free;
	logic             finish, rotate, go_left;
	logic [PW:0]      fwd_dist;
	logic [DATA_WIDTH-1:0] port_data;
	logic signed [DATA_WIDTH-1:0] popped_d;
	logic             match_d;
	cdq_pkg::ring_cmd_t ring_cmd;

	assign is_push     = (act_q == cdq_pkg::ACT_PUSH_FRONT) || (act_q == cdq_pkg::ACT_PUSH_BACK);
	assign full        = (cnt_q == CNT_FULL);
	assign empty       = (cnt_q == '0);
	assign need_access = is_push ? !full : !empty;
	assign at_slot     = (rot_q == tgt_q);
	assign out_free    = !rsp_valid_q || rsp_ready;

	always_comb begin
		if (tgt_q >= rot_q) begin
			fwd_dist = {1'b0, tgt_q} - {1'b0, rot_q};
		end else begin
			fwd_dist = {1'b0, tgt_q} + (PW+1)'(DEPTH) - {1'b0, rot_q};
		end
	end

	assign go_left = (fwd_dist <= (PW+1)'(HALF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		finish    = 1'b0;
		rotate    = 1'b0;
		unique case (state_q)
			cdq_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = cdq_pkg::ST_SEEK;
				end
			end
			cdq_pkg::ST_SEEK: begin
				if (need_access && !at_slot) begin
					rotate = 1'b1;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = cdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (cdq_pkg::action_t'(action))
			cdq_pkg::ACT_PUSH_FRONT: tgt_d = ptr_dec(front_q);
			cdq_pkg::ACT_POP_FRONT:  tgt_d = front_q;
			cdq_pkg::ACT_PUSH_BACK:  tgt_d = back_q;
			cdq_pkg::ACT_POP_BACK:   tgt_d = ptr_dec(back_q);
			default:                 tgt_d = front_q;
		endcase
	end

	// latch the command at accept
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			act_q <= cdq_pkg::action_t'(action);
			val_q <= value;
			tgt_q <= tgt_d;
		end
	end

	assign ring_cmd.rot_left  = rotate && go_left;
	assign ring_cmd.rot_right = rotate && !go_left;
	assign ring_cmd.load      = finish && is_push && !full;

	cdq_ring #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ring (
		.clk      (clk),
		.cmd      (ring_cmd),
		.load_data(val_q),
		.port_data(port_data)
	);

	always_comb begin
		if (is_push) begin
			popped_d = '0;
			match_d  = 1'b1;
		end else begin
			popped_d = empty ? '1 : $signed(port_data);
			match_d  = (popped_d == val_q);
		end
		all_ok_d = all_ok_q && match_d;
		if (is_push && !full) begin
			cnt_d = cnt_q + 1'b1;
		end else if (!is_push && !empty) begin
			cnt_d = cnt_q - 1'b1;
		end else begin
			cnt_d = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q       <= '0;
			front_q     <= '0;
			back_q      <= '0;
			cnt_q       <= '0;
			all_ok_q    <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ring_cmd.rot_left) begin
				rot_q <= ptr_inc(rot_q);
			end else if (ring_cmd.rot_right) begin
				rot_q <= ptr_dec(rot_q);
			end
			if (finish) begin
				cnt_q       <= cnt_d;
				all_ok_q    <= all_ok_d;
				rsp_valid_q <= 1'b1;
				if (need_access) begin
					case (act_q)
						cdq_pkg::ACT_PUSH_FRONT: front_q <= tgt_q;
						cdq_pkg::ACT_POP_FRONT:  front_q <= ptr_inc(tgt_q);
						cdq_pkg::ACT_PUSH_BACK:  back_q  <= ptr_inc(tgt_q);
						cdq_pkg::ACT_POP_BACK:   back_q  <= tgt_q;
						default:                 back_q  <= back_q;
					endcase
				end
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the response until taken
	always_ff @(posedge clk) begin
		if (finish) begin
			popped_value <= popped_d;
			was_empty    <= !is_push && empty;
			overflowed   <= is_push && full;
			matched      <= match_d;
			all_matched  <= all_ok_d;
			occupancy    <= cnt_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = cdq_pkg::DEPTH_DEF;
	localparam int DW    = cdq_pkg::DATA_WIDTH_DEF;
	localparam int OW    = $clog2(DEPTH + 1);
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int CALM_TAIL = 120;

	typedef struct packed {
		logic [DW-1:0] popped;
		logic          empty;
		logic          over;
		logic          match;
		logic          all_ok;
		logic [OW-1:0] occ;
	} deque_rsp_t;

	typedef struct packed {
		cdq_pkg::action_t act;
		logic [DW-1:0] val;
		logic       typed;
		deque_rsp_t want;
	} stim_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_ready;
	logic [1:0]    action    = '0;
	logic [DW-1:0] value     = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	logic [DW-1:0] popped_value;
	logic          was_empty;
	logic          overflowed;
	logic          matched;
	logic          all_matched;
	logic [OW-1:0] occupancy;

	circular_deque_checker_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.action(action),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.popped_value(popped_value),
		.was_empty(was_empty),
		.overflowed(overflowed),
		.matched(matched),
		.all_matched(all_matched),
		.occupancy(occupancy)
	);

	always #5 clk = ~clk;

	logic [DW-1:0] ring [DEPTH];
	int            head_ptr = 0;
	int            tail_ptr = 0;
	int            fill_cnt = 0;
	logic          clean    = 1'b1;

	deque_rsp_t    rsp_expect_q [$];
	stim_row_t     stim [$];
	logic [DW-1:0] gen_q [$];
	int            errors = 0;
	int unsigned   cycles = 0;
	logic          calm   = 1'b0;
	int            stall_left = 0;

	function automatic deque_rsp_t deque_apply(cdq_pkg::action_t act, logic [DW-1:0] val);
		deque_rsp_t r;
		r.popped = '0;
		r.empty  = 1'b0;
		r.over   = 1'b0;
		r.match  = 1'b1;
		if (act == cdq_pkg::ACT_PUSH_FRONT || act == cdq_pkg::ACT_PUSH_BACK) begin
			if (fill_cnt >= DEPTH) begin
				r.over = 1'b1;
			end else if (act == cdq_pkg::ACT_PUSH_FRONT) begin
				head_ptr = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
				ring[head_ptr] = val;
				fill_cnt++;
			end else begin
				ring[tail_ptr] = val;
				tail_ptr = (tail_ptr == DEPTH - 1) ? 0 : tail_ptr + 1;
				fill_cnt++;
			end
		end else begin
			if (fill_cnt == 0) begin
				r.popped = '1;
				r.empty  = 1'b1;
			end else if (act == cdq_pkg::ACT_POP_FRONT) begin
				r.popped = ring[head_ptr];
				head_ptr = (head_ptr == DEPTH - 1) ? 0 : head_ptr + 1;
				fill_cnt--;
			end else begin
				tail_ptr = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
				r.popped = ring[tail_ptr];
				fill_cnt--;
			end
			r.match = (r.popped == val);
			if (!r.match)
				clean = 1'b0;
		end
		r.all_ok = clean;
		r.occ    = OW'(fill_cnt);
		return r;
	endfunction

	task automatic add_row(cdq_pkg::action_t a, logic [DW-1:0] v, logic [DW-1:0] p, logic e,
			logic o, logic m, logic am, int occ);
		stim_row_t s;
		s.act         = a;
		s.val         = v;
		s.typed       = 1'b1;
		s.want.popped = p;
		s.want.empty  = e;
		s.want.over   = o;
		s.want.match  = m;
		s.want.all_ok = am;
		s.want.occ    = OW'(occ);
		stim.push_back(s);
	endtask

	task automatic gen_op(cdq_pkg::action_t a);
		stim_row_t     s;
		logic [DW-1:0] v;
		logic [DW-1:0] w;
		v = DW'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = '0;
				1: v = '1;
				2: v = {1'b0, {(DW-1){1'b1}}};
				default: v = {1'b1, {(DW-1){1'b0}}};
			endcase
		end
		case (a)
			cdq_pkg::ACT_PUSH_FRONT: if (gen_q.size() < DEPTH) gen_q.push_front(v);
			cdq_pkg::ACT_PUSH_BACK:  if (gen_q.size() < DEPTH) gen_q.push_back(v);
			default: begin
				if (gen_q.size() == 0) begin
					if ($urandom_range(0, 3) != 0)
						v = '1;
				end else begin
					w = (a == cdq_pkg::ACT_POP_FRONT) ? gen_q.pop_front() : gen_q.pop_back();
					if ($urandom_range(0, 7) != 0)
						v = w;
				end
			end
		endcase
		s.act   = a;
		s.val   = v;
		s.typed = 1'b0;
		s.want  = '0;
		stim.push_back(s);
	endtask

	function automatic cdq_pkg::action_t any_push();
		return $urandom_range(0, 1) ? cdq_pkg::ACT_PUSH_BACK : cdq_pkg::ACT_PUSH_FRONT;
	endfunction

	function automatic cdq_pkg::action_t any_pop();
		return $urandom_range(0, 1) ? cdq_pkg::ACT_POP_BACK : cdq_pkg::ACT_POP_FRONT;
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			rsp_ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : rsp_mon
		deque_rsp_t w;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_expect_q.size() == 0) begin
				$display("%0t: unexpected item popped_value=%h occupancy=%0d", $time,
					popped_value, occupancy);
				errors++;
			end else begin
				w = rsp_expect_q.pop_front();
				if (popped_value !== w.popped) begin
					$display("%0t: popped_value expected %h actual %h", $time, w.popped,
						popped_value);
					errors++;
				end
				if (was_empty !== w.empty) begin
					$display("%0t: was_empty expected %b actual %b", $time, w.empty, was_empty);
					errors++;
				end
				if (overflowed !== w.over) begin
					$display("%0t: overflowed expected %b actual %b", $time, w.over, overflowed);
					errors++;
				end
				if (matched !== w.match) begin
					$display("%0t: matched expected %b actual %b", $time, w.match, matched);
					errors++;
				end
				if (all_matched !== w.all_ok) begin
					$display("%0t: all_matched expected %b actual %b", $time, w.all_ok,
						all_matched);
					errors++;
				end
				if (occupancy !== w.occ) begin
					$display("%0t: occupancy expected %0d actual %0d", $time, w.occ, occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t  s;
		deque_rsp_t r;
		int         i;

		add_row(cdq_pkg::ACT_POP_FRONT,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 1, 1, 0);
		add_row(cdq_pkg::ACT_POP_BACK,   32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 1, 1, 0);
		add_row(cdq_pkg::ACT_PUSH_FRONT, 32'h7FFFFFFF, 32'h00000000, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_PUSH_BACK,  32'h80000000, 32'h00000000, 0, 0, 1, 1, 2);
		add_row(cdq_pkg::ACT_PUSH_FRONT, 32'h00000000, 32'h00000000, 0, 0, 1, 1, 3);
		add_row(cdq_pkg::ACT_PUSH_BACK,  32'hFFFFFFFF, 32'h00000000, 0, 0, 1, 1, 4);
		add_row(cdq_pkg::ACT_POP_FRONT,  32'h00000000, 32'h00000000, 0, 0, 1, 1, 3);
		add_row(cdq_pkg::ACT_POP_BACK,   32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 1, 2);
		add_row(cdq_pkg::ACT_POP_FRONT,  32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_POP_BACK,   32'h80000000, 32'h80000000, 0, 0, 1, 1, 0);
		add_row(cdq_pkg::ACT_PUSH_BACK,  32'h55555555, 32'h00000000, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_PUSH_BACK,  32'hAAAAAAAA, 32'h00000000, 0, 0, 1, 1, 2);
		add_row(cdq_pkg::ACT_POP_FRONT,  32'h55555555, 32'h55555555, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_PUSH_FRONT, 32'h12345678, 32'h00000000, 0, 0, 1, 1, 2);
		add_row(cdq_pkg::ACT_POP_BACK,   32'hAAAAAAAA, 32'hAAAAAAAA, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_POP_BACK,   32'h12345678, 32'h12345678, 0, 0, 1, 1, 0);
		add_row(cdq_pkg::ACT_PUSH_FRONT, 32'h0F0F0F0F, 32'h00000000, 0, 0, 1, 1, 1);
		add_row(cdq_pkg::ACT_POP_FRONT,  32'h00000000, 32'h0F0F0F0F, 0, 0, 0, 0, 0);
		add_row(cdq_pkg::ACT_POP_BACK,   32'h00000000, 32'hFFFFFFFF, 1, 0, 0, 0, 0);
		add_row(cdq_pkg::ACT_POP_FRONT,  32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 1, 0, 0);

		repeat (150) begin
			if (gen_q.size() >= 12 && $urandom_range(0, 9) < 7)
				gen_op(any_pop());
			else
				gen_op(cdq_pkg::action_t'($urandom_range(0, 3)));
		end
		while (gen_q.size() < DEPTH) begin
			if ($urandom_range(0, 19) < 19)
				gen_op(any_push());
			else
				gen_op(any_pop());
		end
		repeat (60) begin
			if (gen_q.size() == DEPTH)
				gen_op($urandom_range(0, 1) ? any_push() : any_pop());
			else
				gen_op($urandom_range(0, 9) < 6 ? any_push() : any_pop());
		end
		repeat (40)
			gen_op(cdq_pkg::action_t'($urandom_range(0, 3)));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < stim.size(); i++) begin
			s = stim[i];
			if (i >= stim.size() - CALM_TAIL)
				calm <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			cmd_valid <= 1'b1;
			action    <= s.act;
			value     <= s.val;
			do @(posedge clk); while (!cmd_ready);
			r = deque_apply(s.act, s.val);
			rsp_expect_q.push_back(s.typed ? s.want : r);
			@(negedge clk);
		end
		cmd_valid <= 1'b0;

		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH / 2 + 16) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
